### src/mbab_pkg.sv
// Shared constants and types of the masked block average binning unit.
package mbab_pkg;

  localparam int IMAGE_SIDE = 4096;
  localparam int BIN_SIDE   = 4;
  localparam int BIN_COUNT  = IMAGE_SIDE / BIN_SIDE;
  localparam int BIN_EDGE   = BIN_COUNT * BIN_SIDE;

  localparam int PIX_W  = 32;
  localparam int POS_W  = $clog2(IMAGE_SIDE);
  localparam int SUB_W  = $clog2(BIN_SIDE);
  localparam int SLOT_W = $clog2(BIN_COUNT);
  localparam int CNT_W  = $clog2(BIN_SIDE * BIN_SIDE + 1);
  localparam int SUM_W  = PIX_W + $clog2(BIN_SIDE * BIN_SIDE);
  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
  } col_entry_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] mean;
    logic                    bin_valid;
    logic                    frame_end;
  } bin_result_t;

endpackage

### src/mbab_col_store.sv
// Column line store: one partial block sum and count per block column.
module mbab_col_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [mbab_pkg::SLOT_W-1:0] wr_addr,
  input  mbab_pkg::col_entry_t       wr_data,
  input  logic                       rd_en,
  input  logic [mbab_pkg::SLOT_W-1:0] rd_addr,
  output mbab_pkg::col_entry_t       rd_data
);

  mbab_pkg::col_entry_t mem [mbab_pkg::BIN_COUNT];
  mbab_pkg::col_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/mbab_divider.sv
// Bit-serial signed divider of a block sum by its valid pixel count.
module mbab_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [mbab_pkg::SUM_W-1:0]  dividend,
  input  logic [mbab_pkg::CNT_W-1:0]         divisor,
  input  logic                               frame_end,
  output logic                               busy,
  output logic                               done,
  input  logic                               take,
  output mbab_pkg::bin_result_t              result
);

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  div_state_t                   state_r, state_nxt;
  logic [mbab_pkg::SUM_W-1:0]   quot_r, quot_nxt;
  logic [mbab_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [mbab_pkg::CNT_W-1:0]   dsr_r, dsr_nxt;
  logic [mbab_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         neg_r, neg_nxt;
  logic                         fend_r, fend_nxt;
  logic [mbab_pkg::CNT_W:0]     rem_shift;
  logic                         fits;
  logic [mbab_pkg::SUM_W-1:0]   quot_signed;

  assign rem_shift   = {rem_r, quot_r[mbab_pkg::SUM_W-1]};
  assign fits        = rem_shift >= {1'b0, dsr_r};
  assign quot_signed = neg_r ? (~quot_r + 1'b1) : quot_r;

  always_comb begin
    state_nxt = state_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    dsr_nxt   = dsr_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    fend_nxt  = fend_r;
    unique case (state_r)
      DIV_IDLE: begin
        if (start) begin
          neg_nxt   = dividend[mbab_pkg::SUM_W-1];
          quot_nxt  = dividend[mbab_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
          rem_nxt   = '0;
          dsr_nxt   = divisor;
          fend_nxt  = frame_end;
          step_nxt  = mbab_pkg::STEP_W'(mbab_pkg::SUM_W - 1);
          state_nxt = DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_nxt  = fits ? mbab_pkg::CNT_W'(rem_shift - {1'b0, dsr_r})
                        : rem_shift[mbab_pkg::CNT_W-1:0];
        quot_nxt = {quot_r[mbab_pkg::SUM_W-2:0], fits};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (take) begin
          state_nxt = DIV_IDLE;
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    fend_r <= fend_nxt;
  end

  assign busy = state_r != DIV_IDLE;
  assign done = state_r == DIV_DONE;

  always_comb begin
    result.bin_valid = dsr_r != '0;
    result.frame_end = fend_r;
    result.mean      = (dsr_r != '0) ? quot_signed[mbab_pkg::PIX_W-1:0] : '0;
  end

endmodule

### src/masked_block_average_binning_unit.sv
// Top level of the masked block average binning unit.
// Path: a block's last pixel passes the p1 register, the bit-serial divider and the output register.
// Throughput: one pixel per cycle, except that the bit-serial divider stalls input while it divides
// after each block's last pixel, and longer while the output register is held.
// Reset: synchronous, active low; clears position, row accumulators and handshake state.
// The column line store has no reset; every entry is written on a block's first row.
module masked_block_average_binning_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mbab_pkg::PIX_W-1:0]  in_pixel_value,
  input  logic                               in_pixel_valid,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mbab_pkg::PIX_W-1:0]  out_bin_mean,
  output logic                               out_bin_valid,
  output logic                               out_frame_end
);

  logic                               accept;
  logic [mbab_pkg::POS_W-1:0]         col_r, col_nxt, row_r, row_nxt;
  logic [mbab_pkg::SUB_W-1:0]         sub_col_r, sub_col_nxt, sub_row_r, sub_row_nxt;
  logic [mbab_pkg::SLOT_W-1:0]        slot_r, slot_nxt;
  logic signed [mbab_pkg::SUM_W-1:0]  row_sum_r, row_sum_nxt;
  logic [mbab_pkg::CNT_W-1:0]         row_cnt_r, row_cnt_nxt;

  logic [mbab_pkg::POS_W-1:0]         col_cur, row_cur;
  logic [mbab_pkg::SUB_W-1:0]         sub_col_cur, sub_row_cur;
  logic [mbab_pkg::SLOT_W-1:0]        slot_cur;
  logic signed [mbab_pkg::SUM_W-1:0]  sum_base, sum_new;
  logic [mbab_pkg::CNT_W-1:0]         cnt_base, cnt_new;
  logic                               in_range, block_col_end;

  logic                               p1_valid_r;
  logic [mbab_pkg::SLOT_W-1:0]        p1_slot_r;
  logic signed [mbab_pkg::SUM_W-1:0]  p1_sum_r;
  logic [mbab_pkg::CNT_W-1:0]         p1_cnt_r;
  logic                               p1_first_r, p1_last_r, p1_fend_r;

  mbab_pkg::col_entry_t               rd_entry, wr_entry;

  logic                               div_busy, div_done, div_take;
  mbab_pkg::bin_result_t              div_result;
  mbab_pkg::bin_result_t              out_r;
  logic                               out_valid_r;

  assign in_stall = div_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col_cur     = in_frame_start ? '0 : col_r;
    row_cur     = in_frame_start ? '0 : row_r;
    sub_col_cur = in_frame_start ? '0 : sub_col_r;
    sub_row_cur = in_frame_start ? '0 : sub_row_r;
    slot_cur    = in_frame_start ? '0 : slot_r;
  end

  assign in_range = (int'(col_cur) < mbab_pkg::BIN_EDGE)
                 && (int'(row_cur) < mbab_pkg::BIN_EDGE);
  assign block_col_end = sub_col_cur == mbab_pkg::SUB_W'(mbab_pkg::BIN_SIDE - 1);

  always_comb begin
    sum_base = (sub_col_cur == '0) ? '0 : row_sum_r;
    cnt_base = (sub_col_cur == '0) ? '0 : row_cnt_r;
    sum_new  = sum_base + (in_pixel_valid ? mbab_pkg::SUM_W'(in_pixel_value) : '0);
    cnt_new  = cnt_base + mbab_pkg::CNT_W'(in_pixel_valid);
  end

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    sub_col_nxt = sub_col_r;
    sub_row_nxt = sub_row_r;
    slot_nxt    = slot_r;
    row_sum_nxt = row_sum_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (in_range) begin
        row_sum_nxt = sum_new;
        row_cnt_nxt = cnt_new;
      end else if (in_frame_start) begin
        row_sum_nxt = '0;
        row_cnt_nxt = '0;
      end
      if (col_cur == mbab_pkg::POS_W'(mbab_pkg::IMAGE_SIDE - 1)) begin
        col_nxt     = '0;
        sub_col_nxt = '0;
        slot_nxt    = '0;
        if (row_cur == mbab_pkg::POS_W'(mbab_pkg::IMAGE_SIDE - 1)) begin
          row_nxt     = '0;
          sub_row_nxt = '0;
        end else begin
          row_nxt     = row_cur + 1'b1;
          sub_row_nxt = (sub_row_cur == mbab_pkg::SUB_W'(mbab_pkg::BIN_SIDE - 1)) ? '0
                                                                                 : sub_row_cur + 1'b1;
        end
      end else begin
        col_nxt     = col_cur + 1'b1;
        row_nxt     = row_cur;
        sub_row_nxt = sub_row_cur;
        sub_col_nxt = block_col_end ? '0 : sub_col_cur + 1'b1;
        slot_nxt    = block_col_end ? slot_cur + 1'b1 : slot_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      sub_col_r   <= '0;
      sub_row_r   <= '0;
      slot_r      <= '0;
      row_sum_r   <= '0;
      row_cnt_r   <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sub_col_r   <= sub_col_nxt;
      sub_row_r   <= sub_row_nxt;
      slot_r      <= slot_nxt;
      row_sum_r   <= row_sum_nxt;
      row_cnt_r   <= row_cnt_nxt;
      p1_valid_r  <= accept && in_range && block_col_end;
      if (div_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_slot_r  <= slot_cur;
      p1_sum_r   <= sum_new;
      p1_cnt_r   <= cnt_new;
      p1_first_r <= sub_row_cur == '0;
      p1_last_r  <= sub_row_cur == mbab_pkg::SUB_W'(mbab_pkg::BIN_SIDE - 1);
      p1_fend_r  <= (col_cur == mbab_pkg::POS_W'(mbab_pkg::BIN_EDGE - 1))
                 && (row_cur == mbab_pkg::POS_W'(mbab_pkg::BIN_EDGE - 1));
    end
    if (div_take) begin
      out_r <= div_result;
    end
  end

  always_comb begin
    wr_entry.sum = p1_first_r ? p1_sum_r : rd_entry.sum + p1_sum_r;
    wr_entry.cnt = p1_first_r ? p1_cnt_r : rd_entry.cnt + p1_cnt_r;
  end

  mbab_col_store u_col_store (
    .clk     (clk),
    .wr_en   (p1_valid_r),
    .wr_addr (p1_slot_r),
    .wr_data (wr_entry),
    .rd_en   (accept),
    .rd_addr (slot_cur),
    .rd_data (rd_entry)
  );

  assign div_take = div_done && (!out_valid_r || !out_stall);

  mbab_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (p1_valid_r && p1_last_r),
    .dividend  (wr_entry.sum),
    .divisor   (wr_entry.cnt),
    .frame_end (p1_fend_r),
    .busy      (div_busy),
    .done      (div_done),
    .take      (div_take),
    .result    (div_result)
  );

  assign out_valid     = out_valid_r;
  assign out_bin_mean  = out_r.mean;
  assign out_bin_valid = out_r.bin_valid;
  assign out_frame_end = out_r.frame_end;

endmodule
